>>> rtl/motor_state_shift_chain_driver_assert.svh
// ----------------------------------------------------------------------------
// motor state shift chain driver assertion macros
// shared property forms for the concurrent checks of the driver
// ----------------------------------------------------------------------------
`ifndef MOTOR_STATE_SHIFT_CHAIN_DRIVER_ASSERT_SVH
`define MOTOR_STATE_SHIFT_CHAIN_DRIVER_ASSERT_SVH

// same-cycle implication, held off during reset
`define MSSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define MSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mssc_pkg.sv
// ----------------------------------------------------------------------------
// mssc_pkg
// request kinds, fill constants and controller/datapath interface structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mssc_pkg;

    localparam logic [1:0] KIND_SET  = 2'd0;
    localparam logic [1:0] KIND_STOP = 2'd1;
    localparam logic [1:0] KIND_OPEN = 2'd2;
    localparam logic [1:0] KIND_PUSH = 2'd3;

    localparam logic [1:0] STATUS_MASK = 2'b11;
    localparam logic [7:0] BYTE_ONES   = 8'hFF;

    typedef struct packed {
        logic load;
        logic write_set;
        logic fill;
        logic emit_ack;
        logic emit_bit;
        logic step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic shift_last;
    } t_ctrl_sts;

endpackage

>>> rtl/motor_state_shift_chain_driver.sv
// ----------------------------------------------------------------------------
// motor_state_shift_chain_driver: set-motor request loads, writes its status pair, then answers
// stop, open and push requests fill, then give 8 * modules results, one a cycle
// next start accepted once busy drops
// sync active-low reset clears every module byte and sets modules in use to 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "motor_state_shift_chain_driver_assert.svh"

module motor_state_shift_chain_driver #(
    parameter int MAX_MODULES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic [4:0] i_motor_index,
    input  logic [1:0] i_motor_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data,
    output logic       o_result_valid,
    output logic       o_serial_bit,
    output logic       o_last_bit,
    output logic       o_accepted,
    output logic       o_all_stopped
);

    mssc_pkg::t_ctrl_cmd cmd;
    mssc_pkg::t_ctrl_sts sts;

    mssc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mssc_datapath #(
        .MAX_MODULES (MAX_MODULES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_motor_index  (i_motor_index),
        .i_motor_status (i_motor_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_serial_bit   (o_serial_bit),
        .o_last_bit     (o_last_bit),
        .o_accepted     (o_accepted),
        .o_all_stopped  (o_all_stopped)
    );

    assign o_cfg_ready = 1'b1;

    `MSSC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised")
    `MSSC_ASSERT_IMPLY(a_last_idle, i_clk, i_rst_n, o_result_valid && o_last_bit, !busy, "still busy after final bit")
    `MSSC_ASSERT_IMPLY(a_last_strobe, i_clk, i_rst_n, o_last_bit, o_result_valid && o_accepted, "last bit outside a shift result")
    `MSSC_ASSERT_IMPLY(a_bit_strobe, i_clk, i_rst_n, o_serial_bit, o_result_valid && o_accepted, "data bit outside a shift result")

endmodule

>>> rtl/mssc_ctrl.sv
// ----------------------------------------------------------------------------
// mssc_ctrl
// sequencer: decodes a request, then runs the set or fill-and-shift steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mssc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_kind,
    input  mssc_pkg::t_ctrl_sts i_sts,
    output mssc_pkg::t_ctrl_cmd o_cmd,
    output logic               o_busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SET   = 5'b00010,
        S_ACK   = 5'b00100,
        S_FILL  = 5'b01000,
        S_SHIFT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_kind == mssc_pkg::KIND_SET) ? S_SET : S_FILL;
                end
            end
            S_SET: begin
                o_cmd.write_set = 1'b1;
                n_state         = S_ACK;
            end
            S_ACK: begin
                o_cmd.emit_ack = 1'b1;
                n_state        = S_IDLE;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.emit_bit = 1'b1;
                o_cmd.step     = 1'b1;
                if (i_sts.shift_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> rtl/mssc_datapath.sv
// ----------------------------------------------------------------------------
// mssc_datapath
// module byte store, set/fill update, bit shifter and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mssc_datapath #(
    parameter int MAX_MODULES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mssc_pkg::t_ctrl_cmd i_cmd,
    output mssc_pkg::t_ctrl_sts o_sts,
    input  logic [1:0]          i_kind,
    input  logic [4:0]          i_motor_index,
    input  logic [1:0]          i_motor_status,
    input  logic                i_cfg_valid,
    input  logic [3:0]          i_cfg_data,
    output logic                o_result_valid,
    output logic                o_serial_bit,
    output logic                o_last_bit,
    output logic                o_accepted,
    output logic                o_all_stopped
);

    localparam int         AW    = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam logic [3:0] MAX_N = 4'(MAX_MODULES);

    logic [3:0]    r_cfg;
    logic [7:0]    r_bytes [MAX_MODULES];
    logic [AW-1:0] r_addr;
    logic [2:0]    r_bit;
    logic [1:0]    r_kind;
    logic [1:0]    r_slot;
    logic [1:0]    r_status;
    logic          r_ok;

    logic          r_strobe;
    logic          r_serial;
    logic          r_last;
    logic          r_acc;
    logic          r_idle;

    logic [3:0]    n_active;
    logic [7:0]    sel_byte;
    logic [7:0]    set_mask;
    logic [7:0]    set_val;
    logic          cur_bit;
    logic          shift_last;
    logic          chain_idle;

    // zero modules counts as one, oversize saturates
    always_comb begin
        if (r_cfg == 4'd0) begin
            n_active = 4'd1;
        end else if (r_cfg > MAX_N) begin
            n_active = MAX_N;
        end else begin
            n_active = r_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 4'd1;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    assign sel_byte   = r_bytes[r_addr];
    assign set_mask   = 8'(mssc_pkg::STATUS_MASK) << {r_slot, 1'b0};
    assign set_val    = 8'(r_status) << {r_slot, 1'b0};
    assign cur_bit    = sel_byte[r_bit];
    assign shift_last = (r_addr == '0) && (r_bit == 3'd0);

    // only bytes in use count toward the idle flag
    always_comb begin
        chain_idle = 1'b1;
        for (int m = 0; m < MAX_MODULES; m++) begin
            if ((4'(m) < n_active) && (r_bytes[m] != 8'd0)) begin
                chain_idle = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MAX_MODULES; m++) begin
                r_bytes[m] <= 8'd0;
            end
        end else if (i_cmd.write_set) begin
            if (r_ok) begin
                r_bytes[r_addr] <= (sel_byte & ~set_mask) | set_val;
            end
        end else if (i_cmd.fill) begin
            for (int m = 0; m < MAX_MODULES; m++) begin
                if (4'(m) < n_active) begin
                    case (r_kind)
                        mssc_pkg::KIND_STOP: r_bytes[m] <= 8'd0;
                        mssc_pkg::KIND_OPEN: r_bytes[m] <= mssc_pkg::BYTE_ONES;
                        mssc_pkg::KIND_PUSH: r_bytes[m] <= r_bytes[m];
                        default:             r_bytes[m] <= r_bytes[m];
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_slot   <= i_motor_index[1:0];
            r_status <= i_motor_status;
            r_ok     <= ({1'b0, i_motor_index[4:2]} < n_active);
            r_addr   <= AW'(i_motor_index[4:2]);
        end else if (i_cmd.fill) begin
            r_addr <= AW'(n_active - 4'd1);
            r_bit  <= 3'd7;
        end else if (i_cmd.step) begin
            if (r_bit == 3'd0) begin
                r_bit  <= 3'd7;
                r_addr <= r_addr - 1'b1;
            end else begin
                r_bit <= r_bit - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_ack | i_cmd.emit_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_serial <= i_cmd.emit_bit & cur_bit;
        r_last   <= i_cmd.emit_bit & shift_last;
        r_acc    <= i_cmd.emit_bit | (i_cmd.emit_ack & r_ok);
        r_idle   <= chain_idle;
    end

    assign o_sts.shift_last = shift_last;
    assign o_result_valid   = r_strobe;
    assign o_serial_bit     = r_serial;
    assign o_last_bit       = r_last;
    assign o_accepted       = r_acc;
    assign o_all_stopped    = r_idle;

endmodule
